### hdl/gbnms_pkg.sv
// ----------------------------------------------------------------------------
// gbnms_pkg
// Shared types and constants of the greedy box suppression block: default
// sizes, threshold format, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package gbnms_pkg;

  // default sizes
  localparam int MAX_KEPT_DEF   = 64;
  localparam int COORD_BITS_DEF = 12;

  // box index within a frame wraps at this width
  localparam int INDEX_W = 12;

  // iou threshold in q1.8
  localparam int THR_W     = 9;
  localparam int IOU_SHIFT = 8;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted item, restart the scan
    logic issue;   // read the next kept box and send it down the compare pipe
    logic finish;  // store the box if kept and there is room, load the result, advance frame state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // every kept box has been read
    logic pipe_busy;  // compares still in flight
    logic out_free;   // result register can take a new item
  } sts_t;

endpackage

### hdl/gbnms_ram.sv
// ----------------------------------------------------------------------------
// gbnms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gbnms_ram #(
  parameter int WIDTH = 4 * gbnms_pkg::COORD_BITS_DEF,
  parameter int DEPTH = gbnms_pkg::MAX_KEPT_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/gbnms_ctrl.sv
// ----------------------------------------------------------------------------
// gbnms_ctrl
// Controller: accepts one item, walks the kept-box store, waits for the
// compare pipe to drain, then hands the result to the output register.
// ----------------------------------------------------------------------------
module gbnms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbnms_pkg::sts_t   sts,
  output gbnms_pkg::cmd_t   cmd
);
  import gbnms_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = !sts.scan_done;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/gbnms_dpath.sv
// ----------------------------------------------------------------------------
// gbnms_dpath
// Datapath: current box, kept-box store, five-stage iou compare pipe, frame
// counters, threshold register and the result register.
// ----------------------------------------------------------------------------
module gbnms_dpath #(
  parameter int MAX_KEPT   = gbnms_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = gbnms_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gbnms_pkg::cmd_t                cmd,
  output gbnms_pkg::sts_t                sts,
  input  logic                           cfg_wr_en,
  input  logic [gbnms_pkg::THR_W-1:0]    cfg_wr_data,
  input  logic [COORD_BITS-1:0]          in_box_left,
  input  logic [COORD_BITS-1:0]          in_box_top,
  input  logic [COORD_BITS-1:0]          in_box_width,
  input  logic [COORD_BITS-1:0]          in_box_height,
  input  logic                           in_last_in_frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_keep,
  output logic [gbnms_pkg::INDEX_W-1:0]  out_box_index,
  output logic                           out_store_full,
  output logic                           out_frame_end
);
  import gbnms_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int AREA_W = 2 * CB;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_W + UNI_W;
  localparam int BOX_W  = 4 * CB;
  localparam int CW     = $clog2(MAX_KEPT + 1);
  localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  // overlap length of [a0, a0+al) and [b0, b0+bl), never longer than al
  function automatic logic [CB-1:0] span_ov(input logic [CB-1:0] a0,
                                            input logic [CB-1:0] al,
                                            input logic [CB-1:0] b0,
                                            input logic [CB-1:0] bl);
    logic [CB:0] lo;
    logic [CB:0] ae;
    logic [CB:0] be;
    logic [CB:0] hi;
    logic [CB:0] df;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    df = (hi > lo) ? (hi - lo) : '0;
    return df[CB-1:0];
  endfunction

  // current item
  logic [CB-1:0]     cur_left_r, cur_top_r, cur_width_r, cur_height_r;
  logic              cur_last_r;
  logic [AREA_W-1:0] area_cur_r;

  // frame state and threshold
  logic [THR_W-1:0]   thr_r;
  logic [CW-1:0]      kept_cnt_r;
  logic [CW-1:0]      scan_cnt_r;
  logic [INDEX_W-1:0] frame_idx_r;

  // compare pipe
  logic              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [CB-1:0]     ix_r, iy_r;
  logic [AREA_W-1:0] ab1_r, ab2_r, inter_r, inter3_r;
  logic [UNI_W-1:0]  uni_r;
  logic [PROD_W-1:0] prod_r, ish_r;
  logic              sup_r;

  // result register
  logic               out_valid_r, out_keep_r, out_store_full_r, out_frame_end_r;
  logic [INDEX_W-1:0] out_box_index_r;

  // store port signals
  logic [BOX_W-1:0] ram_rdata;
  logic [CB-1:0]    kb_left, kb_top, kb_width, kb_height;
  logic             room, keep, store_we;

  assign {kb_left, kb_top, kb_width, kb_height} = ram_rdata;
  assign room     = kept_cnt_r < CW'(MAX_KEPT);
  assign keep     = !sup_r;
  assign store_we = cmd.finish && keep && room;

  // kept-box store
  gbnms_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (kept_cnt_r[AW-1:0]),
    .wdata ({cur_left_r, cur_top_r, cur_width_r, cur_height_r}),
    .re    (cmd.issue),
    .raddr (scan_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // current item and its area
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_left_r   <= in_box_left;
      cur_top_r    <= in_box_top;
      cur_width_r  <= in_box_width;
      cur_height_r <= in_box_height;
      cur_last_r   <= in_last_in_frame;
      area_cur_r   <= AREA_W'(in_box_width) * AREA_W'(in_box_height);
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (cmd.load) begin
      scan_cnt_r <= '0;
    end else if (cmd.issue) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
  end

  // pipe valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // overlap spans and kept-box area
  always_ff @(posedge clk) begin
    if (v0_r) begin
      ix_r  <= span_ov(cur_left_r, cur_width_r, kb_left, kb_width);
      iy_r  <= span_ov(cur_top_r, cur_height_r, kb_top, kb_height);
      ab1_r <= AREA_W'(kb_width) * AREA_W'(kb_height);
    end
  end

  // intersection area
  always_ff @(posedge clk) begin
    if (v1_r) begin
      inter_r <= AREA_W'(ix_r) * AREA_W'(iy_r);
      ab2_r   <= ab1_r;
    end
  end

  // union area
  always_ff @(posedge clk) begin
    if (v2_r) begin
      uni_r    <= UNI_W'(area_cur_r) + UNI_W'(ab2_r) - UNI_W'(inter_r);
      inter3_r <= inter_r;
    end
  end

  // threshold times union against scaled intersection
  always_ff @(posedge clk) begin
    if (v3_r) begin
      prod_r <= PROD_W'(thr_r) * PROD_W'(uni_r);
      ish_r  <= PROD_W'(inter3_r) << IOU_SHIFT;
    end
  end

  // suppress flag collects over the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r <= 1'b0;
    end else if (cmd.load) begin
      sup_r <= 1'b0;
    end else if (v4_r && (ish_r > prod_r)) begin
      sup_r <= 1'b1;
    end
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_cnt_r  <= '0;
      frame_idx_r <= '0;
    end else if (cmd.finish) begin
      if (cur_last_r) begin
        kept_cnt_r  <= '0;
        frame_idx_r <= '0;
      end else begin
        if (store_we) kept_cnt_r <= kept_cnt_r + CW'(1);
        frame_idx_r <= frame_idx_r + INDEX_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_keep_r       <= keep;
      out_box_index_r  <= frame_idx_r;
      out_store_full_r <= keep && !room;
      out_frame_end_r  <= cur_last_r;
    end
  end

  // status to controller
  assign sts.scan_done = (scan_cnt_r == kept_cnt_r);
  assign sts.pipe_busy = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_keep       = out_keep_r;
  assign out_box_index  = out_box_index_r;
  assign out_store_full = out_store_full_r;
  assign out_frame_end  = out_frame_end_r;

endmodule

### hdl/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy iou-based non-maximum suppression over score-sorted boxes of a frame.
// ----------------------------------------------------------------------------
// One box is taken at a time. It is compared with each box kept so far in the
// frame, one compare per cycle, through the read port of the kept-box RAM and a
// five-stage compare pipe. At most MAX_KEPT boxes are stored per frame. The
// result sits in an output register, so the next box is accepted while it
// waits to be taken.
// The threshold register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
  parameter int MAX_KEPT   = gbnms_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = gbnms_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gbnms_pkg::THR_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COORD_BITS-1:0]          in_box_left,
  input  logic [COORD_BITS-1:0]          in_box_top,
  input  logic [COORD_BITS-1:0]          in_box_width,
  input  logic [COORD_BITS-1:0]          in_box_height,
  input  logic                           in_last_in_frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_keep,
  output logic [gbnms_pkg::INDEX_W-1:0]  out_box_index,
  output logic                           out_store_full,
  output logic                           out_frame_end
);
  import gbnms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  gbnms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, compare pipe and result register
  gbnms_dpath #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_box_left      (in_box_left),
    .in_box_top       (in_box_top),
    .in_box_width     (in_box_width),
    .in_box_height    (in_box_height),
    .in_last_in_frame (in_last_in_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_keep         (out_keep),
    .out_box_index    (out_box_index),
    .out_store_full   (out_store_full),
    .out_frame_end    (out_frame_end)
  );

endmodule

### hdl/gbnms_chk.sv
// ----------------------------------------------------------------------------
// gbnms_chk
// Port-level checks of the suppression block, bound to the top level.
// ----------------------------------------------------------------------------
module gbnms_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_keep,
  input logic [gbnms_pkg::INDEX_W-1:0]  out_box_index,
  input logic                           out_store_full,
  input logic                           out_frame_end
);
  import gbnms_pkg::*;

  logic [INDEX_W-1:0] exp_idx_r;

  // expected index of the next result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_frame_end ? '0 : (exp_idx_r + INDEX_W'(1));
    end
  end

  // a box reported as not stored must be a kept box
  a_full_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep || !out_store_full))
    else $error("store_full set on a suppressed box");

  // indices count up within a frame and restart after the frame end
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_box_index == exp_idx_r))
    else $error("box index out of sequence");

  // one item at a time: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an acceptance");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_keep)
      && $stable(out_box_index) && $stable(out_store_full) && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind greedy_box_nms gbnms_chk u_gbnms_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_keep       (out_keep),
  .out_box_index  (out_box_index),
  .out_store_full (out_store_full),
  .out_frame_end  (out_frame_end)
);
